>>> hdl/prs_pkg.sv
// Shared types and constants for the power rail sequencer.
// Holds the one-hot mode encoding, LED codes, state and result records.
// No dependencies.
`default_nettype none

package prs_pkg;

    localparam int unsigned DelayW = 8;
    localparam logic [DelayW-1:0] START_DELAY_RESET = 8'd10;
    localparam logic [DelayW-1:0] COUNT_MAX = 8'hFF;

    localparam int unsigned InW  = 13;
    localparam int unsigned InTdataW  = 16;
    localparam int unsigned OutW = 19;
    localparam int unsigned OutTdataW = 24;

    // status byte bit positions
    localparam int unsigned ST_BOARD_OK    = 7;
    localparam int unsigned ST_BOARD_FAULT = 6;
    localparam int unsigned ST_MOTOR_OK    = 5;
    localparam int unsigned ST_MOTOR_FAULT = 4;
    localparam int unsigned ST_HSM_GOOD    = 2;
    localparam int unsigned ST_HSM_FAULT   = 1;
    localparam int unsigned ST_ACK         = 0;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_RED   = 2'd1;
    localparam logic [1:0] LED_GREEN = 2'd2;

    typedef enum logic [8:0] {
        MODE_START       = 9'b000000001,
        MODE_READY       = 9'b000000010,
        MODE_ON_BOARD    = 9'b000000100,
        MODE_ON_ALL      = 9'b000001000,
        MODE_OFF_ALL     = 9'b000010000,
        MODE_FAULT       = 9'b000100000,
        MODE_FAULT_BOARD = 9'b001000000,
        MODE_FAULT_MOTOR = 9'b010000000,
        MODE_FAULT_BOTH  = 9'b100000000
    } mode_t;

    localparam logic [3:0] CODE_START       = 4'd0;
    localparam logic [3:0] CODE_READY       = 4'd1;
    localparam logic [3:0] CODE_ON_BOARD    = 4'd2;
    localparam logic [3:0] CODE_ON_ALL      = 4'd3;
    localparam logic [3:0] CODE_OFF_ALL     = 4'd4;
    localparam logic [3:0] CODE_FAULT       = 4'd5;
    localparam logic [3:0] CODE_FAULT_BOARD = 4'd6;
    localparam logic [3:0] CODE_FAULT_MOTOR = 4'd7;
    localparam logic [3:0] CODE_FAULT_BOTH  = 4'd8;

    typedef struct packed {
        mode_t             mode;
        logic [DelayW-1:0] start_count;
        logic              board_en;
        logic              motor_en;
        logic              hsm_en;
        logic              pend_one;
        logic              pend_two;
        logic              rflag_one;
        logic              rflag_two;
        logic [1:0]        colour_one;
        logic [1:0]        colour_two;
    } prs_state_t;

    typedef struct packed {
        logic [7:0] control_byte;
        logic [1:0] led_two;
        logic [1:0] led_one;
        logic       hsm_on;
        logic       motor_rail_on;
        logic       board_rail_on;
        logic [3:0] mode_code;
    } prs_result_t;

    function automatic logic [3:0] mode_to_code(input mode_t m);
        logic [3:0] c;
        unique case (m)
            MODE_START:       c = CODE_START;
            MODE_READY:       c = CODE_READY;
            MODE_ON_BOARD:    c = CODE_ON_BOARD;
            MODE_ON_ALL:      c = CODE_ON_ALL;
            MODE_OFF_ALL:     c = CODE_OFF_ALL;
            MODE_FAULT:       c = CODE_FAULT;
            MODE_FAULT_BOARD: c = CODE_FAULT_BOARD;
            MODE_FAULT_MOTOR: c = CODE_FAULT_MOTOR;
            MODE_FAULT_BOTH:  c = CODE_FAULT_BOTH;
            default:          c = CODE_START;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/prs_step.sv
// Next-state and result logic for one tick of the rail sequencer.
// Purely combinational; uses prs_pkg for state, mode and LED encodings.
`default_nettype none

module prs_step
    import prs_pkg::*;
(
    input  prs_state_t        state_cur,
    input  logic [7:0]        status_byte,
    input  logic              press_one,
    input  logic              press_two,
    input  logic              restart_one,
    input  logic              restart_two,
    input  logic              blink_phase,
    input  logic [DelayW-1:0] start_delay,
    output prs_state_t        state_nxt,
    output prs_result_t       result
);

    logic       board_ok;
    logic       board_f;
    logic       motor_ok;
    logic       motor_f;
    logic       hsm_pg;
    logic       hsm_f;
    logic       ack;
    logic [1:0] blink_green;
    logic [1:0] blink_red;
    prs_state_t sel;
    prs_state_t upd;
    logic [DelayW-1:0] count_inc;

    assign board_ok    = status_byte[ST_BOARD_OK];
    assign board_f     = status_byte[ST_BOARD_FAULT];
    assign motor_ok    = status_byte[ST_MOTOR_OK];
    assign motor_f     = status_byte[ST_MOTOR_FAULT];
    assign hsm_pg      = status_byte[ST_HSM_GOOD];
    assign hsm_f       = status_byte[ST_HSM_FAULT];
    assign ack         = status_byte[ST_ACK];
    assign blink_green = blink_phase ? LED_GREEN : LED_OFF;
    assign blink_red   = blink_phase ? LED_RED : LED_OFF;

    // latch requests, then pick the mode by fault priority
    always_comb
    begin
        sel = state_cur;
        sel.pend_one  = state_cur.pend_one | press_one;
        sel.pend_two  = state_cur.pend_two | press_two;
        sel.rflag_one = state_cur.rflag_one | restart_one;
        sel.rflag_two = state_cur.rflag_two | restart_two;
        priority if (!board_f && !motor_f && !hsm_f)
        begin
            if (sel.pend_one)
            begin
                sel.pend_one = 1'b0;
                sel.mode = state_cur.board_en ? MODE_OFF_ALL : MODE_ON_BOARD;
            end
            if (sel.pend_two)
            begin
                sel.pend_two = 1'b0;
                if (state_cur.motor_en)
                    sel.mode = MODE_ON_BOARD;
                else if (state_cur.board_en)
                    sel.mode = MODE_ON_ALL;
            end
        end
        else if (!board_f)
        begin
            if (sel.pend_one)
            begin
                sel.pend_one = 1'b0;
                sel.mode = state_cur.board_en ? MODE_OFF_ALL : MODE_ON_BOARD;
            end
            else if (!sel.rflag_two)
                sel.mode = MODE_FAULT_MOTOR;
            else
                sel.mode = state_cur.board_en ? MODE_ON_ALL : MODE_OFF_ALL;
        end
        else
        begin
            if (!sel.rflag_one)
                sel.mode = (motor_f || hsm_f) ? MODE_FAULT_BOTH : MODE_FAULT_BOARD;
            else
                sel.mode = MODE_ON_BOARD;
        end
    end

    // saturating count while in start
    assign count_inc = (sel.start_count != COUNT_MAX) ? sel.start_count + 1'b1
                                                      : sel.start_count;

    // advance the start count, drive rails and LEDs from the selected mode
    always_comb
    begin
        upd = sel;
        unique case (sel.mode)
            MODE_START:
            begin
                upd.start_count = count_inc;
                if (count_inc >= start_delay)
                    upd.mode = MODE_READY;
            end
            MODE_READY:
                upd.start_count = '0;
            MODE_OFF_ALL:
            begin
                upd.board_en   = 1'b0;
                upd.motor_en   = 1'b0;
                upd.hsm_en     = 1'b0;
                upd.colour_one = LED_RED;
                upd.colour_two = LED_RED;
            end
            MODE_ON_BOARD:
            begin
                upd.board_en   = 1'b1;
                upd.motor_en   = 1'b0;
                upd.hsm_en     = 1'b0;
                upd.colour_one = board_ok ? LED_GREEN : blink_green;
                upd.colour_two = LED_RED;
            end
            MODE_ON_ALL:
            begin
                upd.board_en   = 1'b1;
                upd.motor_en   = 1'b1;
                upd.hsm_en     = 1'b1;
                upd.colour_one = board_ok ? LED_GREEN : blink_green;
                upd.colour_two = (motor_ok && hsm_pg) ? LED_GREEN : blink_green;
            end
            MODE_FAULT_BOARD:
            begin
                upd.board_en   = 1'b0;
                upd.motor_en   = 1'b0;
                upd.hsm_en     = 1'b0;
                upd.colour_one = blink_red;
                upd.colour_two = LED_RED;
            end
            MODE_FAULT_MOTOR:
            begin
                upd.motor_en   = 1'b0;
                upd.hsm_en     = 1'b0;
                upd.colour_one = LED_GREEN;
                upd.colour_two = blink_red;
            end
            MODE_FAULT_BOTH:
            begin
                upd.board_en   = 1'b0;
                upd.motor_en   = 1'b0;
                upd.hsm_en     = 1'b0;
                upd.colour_one = blink_red;
                upd.colour_two = blink_red;
            end
            MODE_FAULT:
            begin
                upd.colour_one = LED_GREEN;
                upd.colour_two = blink_green;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.mode_code     = mode_to_code(upd.mode);
        result.board_rail_on = upd.board_en;
        result.motor_rail_on = upd.motor_en;
        result.hsm_on        = upd.hsm_en;
        result.led_one       = upd.colour_one;
        result.led_two       = upd.colour_two;
        // restart bit is taken before the acknowledge clears the flags
        result.control_byte  = {upd.board_en, 1'b0, upd.motor_en, 1'b0,
                                upd.hsm_en, 2'b00, upd.rflag_one | upd.rflag_two};
        state_nxt = upd;
        if (ack)
        begin
            state_nxt.rflag_one = 1'b0;
            state_nxt.rflag_two = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/power_rail_sequencer_fsm.sv
// Top level of the power rail sequencer: stream ports, state and output registers.
// Depends on prs_pkg and prs_step.
`default_nettype none

// Sequences the board converter, motor converter and high side switch from one
// status tick per input word and returns one result word per tick. Each tick
// is processed in the cycle it is accepted: the sequencer state and the output
// register update at that edge, so one word per clock is sustained while
// m_tready is high; the result appears on the master side in the next cycle.
// A new word is taken whenever the output register is empty or is being
// drained in the same cycle. start_delay resets to 10; the user must write it
// through cfg_wr_en/cfg_wr_data only while idle, which the block does not enforce.

module power_rail_sequencer_fsm
    import prs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [DelayW-1:0]    cfg_wr_data,  // start_delay
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] status_byte, [8] press_one, [9] press_two, [10] restart_one,
    // [11] restart_two, [12] blink_phase, [15:13] zero
    input  logic [InTdataW-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] mode_code, [4] board_rail_on, [5] motor_rail_on, [6] hsm_on,
    // [8:7] led_one, [10:9] led_two, [18:11] control_byte, [23:19] zero
    output logic [OutTdataW-1:0] m_tdata
);

    prs_state_t        state_reg;
    prs_state_t        state_next;
    prs_result_t       result_next;
    logic [OutW-1:0]   out_data_reg;
    logic              out_valid_reg;
    logic [DelayW-1:0] start_delay_reg;
    logic              in_accept;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutTdataW-OutW){1'b0}}, out_data_reg};

    prs_step u_step (
        .state_cur   (state_reg),
        .status_byte (s_tdata[7:0]),
        .press_one   (s_tdata[8]),
        .press_two   (s_tdata[9]),
        .restart_one (s_tdata[10]),
        .restart_two (s_tdata[11]),
        .blink_phase (s_tdata[12]),
        .start_delay (start_delay_reg),
        .state_nxt   (state_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_delay_reg <= START_DELAY_RESET;
        else if (cfg_wr_en)
            start_delay_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_START;
            state_reg.start_count <= '0;
            state_reg.board_en    <= 1'b0;
            state_reg.motor_en    <= 1'b0;
            state_reg.hsm_en      <= 1'b0;
            state_reg.pend_one    <= 1'b0;
            state_reg.pend_two    <= 1'b0;
            state_reg.rflag_one   <= 1'b0;
            state_reg.rflag_two   <= 1'b0;
            state_reg.colour_one  <= LED_RED;
            state_reg.colour_two  <= LED_RED;
        end
        else if (in_accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= result_next;
    end

    // motor converter and high side switch always switch together
    a_motor_hsm_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.motor_en == state_reg.hsm_en)
        else $error("motor and hsm enables diverged");

    // motor rail never runs without the board rail
    a_motor_needs_board: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.motor_en |-> state_reg.board_en)
        else $error("motor rail on with board rail off");

    // an acknowledged tick leaves no restart flag behind
    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tdata[ST_ACK]) |=> (!state_reg.rflag_one && !state_reg.rflag_two))
        else $error("restart flags survived acknowledge");

endmodule

`default_nettype wire
